// File: rtl/vpma_pkg.sv
package vpma_pkg;

	// Planar memory geometry
	localparam int OFFSET_BITS = 16;
	localparam int ADDR_BITS   = OFFSET_BITS;

	// Command queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

	// Configuration register indexes
	localparam logic [2:0] REG_SET_RESET        = 3'd0;
	localparam logic [2:0] REG_ENABLE_SET_RESET = 3'd1;
	localparam logic [2:0] REG_COMPARE_AND_CARE = 3'd2;
	localparam logic [2:0] REG_ROTATE_AND_FUNC  = 3'd3;
	localparam logic [2:0] REG_READ_PLANE       = 3'd4;
	localparam logic [2:0] REG_MODE_BITS        = 3'd5;
	localparam logic [2:0] REG_BIT_MASK         = 3'd6;
	localparam logic [2:0] REG_PLANE_WRITE_EN   = 3'd7;

	// Logic functions
	localparam logic [1:0] FN_REPLACE = 2'd0;
	localparam logic [1:0] FN_AND     = 2'd1;
	localparam logic [1:0] FN_OR      = 2'd2;
	localparam logic [1:0] FN_XOR     = 2'd3;

	// Write modes
	localparam logic [1:0] WMODE_0 = 2'd0;
	localparam logic [1:0] WMODE_1 = 2'd1;
	localparam logic [1:0] WMODE_2 = 2'd2;
	localparam logic [1:0] WMODE_3 = 2'd3;

	typedef struct packed {
		logic [3:0] set_reset;
		logic [3:0] enable_set_reset;
		logic [7:0] compare_and_care;
		logic [4:0] rotate_and_function;
		logic [1:0] read_plane;
		logic [3:0] mode_bits;
		logic [7:0] bit_mask;
		logic [3:0] plane_write_enable;
	} cfg_t;

	typedef struct packed {
		logic                 is_write;
		logic [ADDR_BITS-1:0] addr;
		logic [7:0]           host_byte;
	} cmd_t;

	typedef struct packed {
		logic clearing;
		logic executing;
	} back_status_t;

endpackage

// File: rtl/vpma_front.sv
module vpma_front (
	input  logic              start,
	input  logic              action,
	input  logic [15:0]       offset,
	input  logic [7:0]        host_byte,
	input  logic              q_full,
	input  logic              clearing,
	output logic              busy,
	output logic              push,
	output vpma_pkg::cmd_t    cmd
);

	// Hold off new commands while memory clears or the queue has no room.
	assign busy = clearing | q_full;
	assign push = start & ~busy;

	// Classify and fold the offset onto the memory depth.
	always_comb begin
		cmd.is_write  = action;
		cmd.addr      = vpma_pkg::ADDR_BITS'(offset);
		cmd.host_byte = host_byte;
	end

endmodule

// File: rtl/vpma_queue.sv
module vpma_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  vpma_pkg::cmd_t    push_cmd,
	input  logic              pop,
	output vpma_pkg::cmd_t    head,
	output logic              full,
	output logic              not_empty
);

	vpma_pkg::cmd_t                   entry_q [vpma_pkg::QUEUE_DEPTH];
	logic [vpma_pkg::QPTR_BITS-1:0]   wr_ptr_q;
	logic [vpma_pkg::QPTR_BITS-1:0]   rd_ptr_q;
	logic [vpma_pkg::QCNT_BITS-1:0]   count_q;

	localparam logic [vpma_pkg::QPTR_BITS-1:0] LAST_PTR =
		vpma_pkg::QPTR_BITS'(vpma_pkg::QUEUE_DEPTH - 1);
	localparam logic [vpma_pkg::QCNT_BITS-1:0] FULL_COUNT =
		vpma_pkg::QCNT_BITS'(vpma_pkg::QUEUE_DEPTH);

	assign full      = (count_q == FULL_COUNT);
	assign not_empty = (count_q != '0);
	assign head      = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: rtl/vpma_back.sv
module vpma_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  vpma_pkg::cfg_t        cfg,
	input  logic                  q_not_empty,
	input  vpma_pkg::cmd_t        head,
	output logic                  pop,
	output vpma_pkg::back_status_t status,
	output logic                  result_valid,
	output logic [7:0]            read_byte
);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_EXEC  = 2'd2;

	localparam logic [vpma_pkg::ADDR_BITS-1:0] LAST_ADDR = '1;

	logic [31:0] mem [2**vpma_pkg::ADDR_BITS];

	logic [1:0]                     state_q;
	logic [vpma_pkg::ADDR_BITS-1:0] clr_addr_q;
	vpma_pkg::cmd_t                 cmd_q;
	logic [31:0]                    rdata_q;
	logic [31:0]                    latch_q;
	logic                           valid_q;
	logic [7:0]                     read_byte_q;

	logic                           mem_we;
	logic [vpma_pkg::ADDR_BITS-1:0] mem_waddr;
	logic [31:0]                    mem_wdata;
	logic [31:0]                    new_word;
	logic [31:0]                    write_data;
	logic [7:0]                     read_result;

	function automatic logic [31:0] spread_byte(input logic [7:0] b);
		return {b, b, b, b};
	endfunction

	function automatic logic [31:0] plane_fill(input logic [3:0] nib);
		return {{8{nib[3]}}, {8{nib[2]}}, {8{nib[1]}}, {8{nib[0]}}};
	endfunction

	function automatic logic [31:0] apply_fn(input logic [1:0] fn, input logic [31:0] d,
		input logic [31:0] m, input logic [31:0] lat);
		logic [31:0] r;
		case (fn)
			vpma_pkg::FN_REPLACE: r = (d & m) | (lat & ~m);
			vpma_pkg::FN_AND:     r = (d | ~m) & lat;
			vpma_pkg::FN_OR:      r = (d & m) | lat;
			default:              r = (d & m) ^ lat;
		endcase
		return r;
	endfunction

	assign pop = (state_q == ST_IDLE) & q_not_empty;

	always_comb begin
		logic [31:0] full_mask;
		logic [15:0] rot_wide;
		logic [31:0] t;
		logic [3:0]  care;
		full_mask = spread_byte(cfg.bit_mask);
		rot_wide  = {cmd_q.host_byte, cmd_q.host_byte} >> cfg.rotate_and_function[2:0];
		case (cfg.mode_bits[1:0])
			vpma_pkg::WMODE_0: write_data = apply_fn(cfg.rotate_and_function[4:3],
				(spread_byte(cmd_q.host_byte) & ~plane_fill(cfg.enable_set_reset))
				| plane_fill(cfg.enable_set_reset & cfg.set_reset), full_mask, latch_q);
			vpma_pkg::WMODE_1: write_data = latch_q;
			vpma_pkg::WMODE_2: write_data = apply_fn(cfg.rotate_and_function[4:3],
				plane_fill(cmd_q.host_byte[3:0]), full_mask, latch_q);
			default:           write_data = apply_fn(cfg.rotate_and_function[4:3],
				plane_fill(cfg.set_reset), spread_byte(rot_wide[7:0]) & full_mask, latch_q);
		endcase
		new_word = (rdata_q & ~plane_fill(cfg.plane_write_enable))
			| (write_data & plane_fill(cfg.plane_write_enable));

		// Colour compare works on the freshly read word.
		care = cfg.compare_and_care[7:4];
		t = (rdata_q & plane_fill(care)) ^ plane_fill(cfg.compare_and_care[3:0] & care);
		if (cfg.mode_bits[3]) begin
			read_result = ~(t[7:0] | t[15:8] | t[23:16] | t[31:24]);
		end else begin
			read_result = rdata_q[{cfg.read_plane, 3'b000} +: 8];
		end
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cmd_q.addr;
		mem_wdata = new_word;
		if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_addr_q;
			mem_wdata = '0;
		end else if (state_q == ST_EXEC) begin
			mem_we = cmd_q.is_write;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rdata_q <= mem[head.addr];
			cmd_q   <= head;
		end
		if ((state_q == ST_EXEC) && !cmd_q.is_write) begin
			read_byte_q <= read_result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
			latch_q    <= '0;
			valid_q    <= 1'b0;
		end else begin
			valid_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == LAST_ADDR) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (pop) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (!cmd_q.is_write) begin
						latch_q <= rdata_q;
						valid_q <= 1'b1;
					end
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign status.clearing  = (state_q == ST_CLEAR);
	assign status.executing = (state_q == ST_EXEC);
	assign result_valid     = valid_q;
	assign read_byte        = read_byte_q;

endmodule

// File: rtl/vga_planar_memory_access_core.sv
// Planar video memory access core. Each transfer on start/busy is one CPU byte
// read or byte write at a word offset of a four-plane memory (one 32-bit word per
// offset, one byte per plane). After reset the core sweeps the memory to zero,
// one word a cycle, with busy held high; configuration writes are taken during
// the sweep. A command is taken at an edge where start is high and busy is low;
// it is classified and queued (two entries), and the back unit executes it: it
// first reads the word from the single-port plane memory, then merges and writes
// it back or forms the read result. The read-then-write on that one memory port
// means the back unit finishes one command before it takes the next; after the
// sweep, busy rises only while the queue is full. A read loads the latch and
// raises result_valid for exactly one cycle with read_byte. The receiver cannot
// stall: it must take read_byte in the cycle result_valid is high. Writes give
// no result. Write configuration registers only while no command is in flight.
module vga_planar_memory_access_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        action,
	input  logic [15:0] offset,
	input  logic [7:0]  host_byte,
	output logic        result_valid,
	output logic [7:0]  read_byte,
	input  logic        write_enable,
	input  logic [2:0]  reg_index,
	input  logic [7:0]  write_data
);

	vpma_pkg::cfg_t         cfg_q;
	vpma_pkg::cmd_t         front_cmd;
	vpma_pkg::cmd_t         q_head;
	vpma_pkg::back_status_t back_status;
	logic                   push;
	logic                   pop;
	logic                   q_full;
	logic                   q_not_empty;

	// Configuration registers: drop the high bits of narrower registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.set_reset           <= '0;
			cfg_q.enable_set_reset    <= '0;
			cfg_q.compare_and_care    <= '0;
			cfg_q.rotate_and_function <= '0;
			cfg_q.read_plane          <= '0;
			cfg_q.mode_bits           <= '0;
			cfg_q.bit_mask            <= 8'hFF;
			cfg_q.plane_write_enable  <= 4'hF;
		end else if (write_enable) begin
			unique case (reg_index)
				vpma_pkg::REG_SET_RESET:        cfg_q.set_reset           <= write_data[3:0];
				vpma_pkg::REG_ENABLE_SET_RESET: cfg_q.enable_set_reset    <= write_data[3:0];
				vpma_pkg::REG_COMPARE_AND_CARE: cfg_q.compare_and_care    <= write_data;
				vpma_pkg::REG_ROTATE_AND_FUNC:  cfg_q.rotate_and_function <= write_data[4:0];
				vpma_pkg::REG_READ_PLANE:       cfg_q.read_plane          <= write_data[1:0];
				vpma_pkg::REG_MODE_BITS:        cfg_q.mode_bits           <= write_data[3:0];
				vpma_pkg::REG_BIT_MASK:         cfg_q.bit_mask            <= write_data;
				vpma_pkg::REG_PLANE_WRITE_EN:   cfg_q.plane_write_enable  <= write_data[3:0];
				default:                        cfg_q <= cfg_q;
			endcase
		end
	end

	// Front: accept and classify the transfer.
	vpma_front u_front (
		.start     (start),
		.action    (action),
		.offset    (offset),
		.host_byte (host_byte),
		.q_full    (q_full),
		.clearing  (back_status.clearing),
		.busy      (busy),
		.push      (push),
		.cmd       (front_cmd)
	);

	// Queue: decouple acceptance from execution.
	vpma_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (front_cmd),
		.pop       (pop),
		.head      (q_head),
		.full      (q_full),
		.not_empty (q_not_empty)
	);

	// Back: clear memory, then read, merge and write back or return the result.
	vpma_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_not_empty  (q_not_empty),
		.head         (q_head),
		.pop          (pop),
		.status       (back_status),
		.result_valid (result_valid),
		.read_byte    (read_byte)
	);

`ifndef SYNTHESIS
	// A command passes the idle and execute states of the back unit, so results never come in adjacent cycles.
	a_no_adjacent_results: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe in two adjacent cycles");

	// Nothing leaves the queue or returns while the memory sweep runs.
	a_quiet_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		back_status.clearing |-> (!pop && !result_valid && busy))
		else $error("activity during memory clear");

	// A popped command is executed in the next cycle.
	a_pop_then_exec: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> back_status.executing)
		else $error("popped command not executed");

	// The front never pushes into a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("push into full queue");
`endif

endmodule
